### rtl/sraq_pkg.sv
// Package for the selective-repeat ARQ window controller: sequence and window sizes,
// action codes, command codes, frame kinds, reset timer lengths and the controller/datapath types. No dependencies.
`default_nettype none
package sraq_pkg;
  // Sequence numbers run modulo SEQ_SPACE; a receive slot is a sequence number modulo WINDOW.
  localparam int MAX_SEQ_NUMBER = 31;
  localparam int SEQ_SPACE      = MAX_SEQ_NUMBER + 1;
  localparam int WINDOW         = 16;

  localparam logic [2:0] ACT_DATA    = 3'd0;
  localparam logic [2:0] ACT_ACK     = 3'd1;
  localparam logic [2:0] ACT_NAK     = 3'd2;
  localparam logic [2:0] ACT_TSTART  = 3'd3;
  localparam logic [2:0] ACT_TSTOP   = 3'd4;
  localparam logic [2:0] ACT_ASTART  = 3'd5;
  localparam logic [2:0] ACT_DELIVER = 3'd6;
  localparam logic [2:0] ACT_STATUS  = 3'd7;

  localparam logic [2:0] CMD_NET   = 3'd0;
  localparam logic [2:0] CMD_PHYS  = 3'd1;
  localparam logic [2:0] CMD_FRAME = 3'd2;
  localparam logic [2:0] CMD_DTO   = 3'd3;
  localparam logic [2:0] CMD_ATO   = 3'd4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  localparam logic [15:0] DATA_TO_RST  = 16'd2500;
  localparam logic [15:0] ACK_TO_RST   = 16'd300;
  localparam logic [15:0] STAGGER_RST  = 16'd800;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,      // capture the event fields
    OP_NET_SEND,   // send next_to_send, bump counters
    OP_PHYS,       // set phys_ready
    OP_ACK_SEND,   // emit ack
    OP_BAD_FRAME,  // nak or ack-timer start on a corrupt frame
    OP_RX_NAK,     // nak on out-of-order data
    OP_RX_MARK,    // set arrived mark
    OP_RX_DELIVER, // deliver expected_rx
    OP_RX_ASTART,  // ack timer start
    OP_NAK_RESEND, // resend frame named by a nak
    OP_TSTOP,      // release oldest_unacked
    OP_TO_SEND,    // resend timed-out frame
    OP_TO_FIRST,   // start successor timer
    OP_TO_NEXT,    // start later timers
    OP_STATUS      // status item
  } op_e;

  typedef struct packed {
    logic ok;
    logic is_data;
    logic is_nak;
    logic nak_cond;     // out-of-order data and NAK allowed
    logic mark_cond;    // frame in rx window and not yet marked
    logic deliver_rdy;  // mark at expected_rx set
    logic resend_cond;  // nak target inside send window
    logic ack_pending;  // tstop loop continues
    logic to_more;      // more timers to start after timeout
    logic net_ok;       // buffer space for a send
  } dp_status_t;
endpackage
`default_nettype wire

### rtl/sraq_datapath.sv
// Datapath of the ARQ window controller: windows, marks, counters and result register.
// Depends on sraq_pkg.
`default_nettype none
module sraq_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sraq_pkg::op_e      op_i,
  input  wire logic               frame_ok_i,
  input  wire logic [1:0]         frame_kind_i,
  input  wire logic [4:0]         frame_seq_i,
  input  wire logic [4:0]         frame_ack_i,
  input  wire logic [4:0]         timeout_seq_i,
  input  wire logic [15:0]        data_timeout_i,
  input  wire logic [15:0]        ack_timeout_i,
  input  wire logic [15:0]        resend_stagger_i,
  output sraq_pkg::dp_status_t    status_o,
  output logic                    valid_o,
  output logic [2:0]              action_o,
  output logic [4:0]              seq_o,
  output logic [4:0]              piggy_ack_o,
  output logic [15:0]             timer_length_o,
  output logic                    network_enable_o,
  output logic                    last_o
);
  import sraq_pkg::*;

  localparam int SeqSpace = SEQ_SPACE;
  localparam int SeqW     = $clog2(SeqSpace);
  localparam int Window   = WINDOW;
  localparam int SlotW = (Window > 1) ? $clog2(Window) : 1;
  localparam int CntW  = $clog2(Window + 1);
  localparam logic [SeqW-1:0] SeqMax = SeqW'(SeqSpace - 1);

  logic [SeqW-1:0] nts_q, old_q, exp_q, rwe_q, fseq_q, fack_q, tseq_q, iter_q;
  logic [CntW-1:0] buf_q;
  logic            nak_ok_q, phys_q;
  logic [Window-1:0] marks_q;
  logic            ok_q;
  logic [1:0]      kind_q;
  logic            rx_ack_q; // ack timer start still owed for this frame

  function automatic logic [SeqW-1:0] inc_f(input logic [SeqW-1:0] v);
    return (v == SeqMax) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [SeqW-1:0] mod_f(input logic [4:0] v);
    logic [5:0] w;
    w = {1'b0, v};
    if (w >= 6'(SeqSpace)) w = w - 6'(SeqSpace);
    return w[SeqW-1:0];
  endfunction

  function automatic logic in_win_f(input logic [SeqW-1:0] lo, input logic [SeqW-1:0] x,
                                    input logic [SeqW-1:0] hi);
    return (lo <= x && x < hi) || (lo <= x && hi < lo) || (x < hi && hi < lo);
  endfunction

  // The window is a power of two that divides the sequence space, so the slot is
  // simply the low bits of the sequence number.
  function automatic logic [SlotW-1:0] slot_f(input logic [SeqW-1:0] s);
    return s[SlotW-1:0];
  endfunction

  logic [SeqW-1:0] piggy;
  logic [16:0]     later_sum;
  logic [15:0]     later;
  logic [SeqW-1:0] nak_tgt;

  assign piggy     = (exp_q == '0) ? SeqMax : exp_q - 1'b1;
  assign later_sum = {1'b0, resend_stagger_i} + {1'b0, ack_timeout_i};
  assign later     = later_sum[16] ? 16'hFFFF : later_sum[15:0];
  assign nak_tgt   = inc_f(fack_q);

  always_comb begin
    status_o.ok          = ok_q;
    status_o.is_data     = (kind_q == KIND_DATA);
    status_o.is_nak      = (kind_q == KIND_NAK);
    status_o.nak_cond    = (fseq_q != exp_q) && nak_ok_q;
    status_o.mark_cond   = in_win_f(exp_q, fseq_q, rwe_q) && !marks_q[slot_f(fseq_q)];
    status_o.deliver_rdy = marks_q[slot_f(exp_q)];
    status_o.resend_cond = in_win_f(old_q, nak_tgt, nts_q);
    status_o.ack_pending = in_win_f(old_q, fack_q, nts_q);
    status_o.to_more     = in_win_f(tseq_q, iter_q, nts_q);
    status_o.net_ok      = (buf_q < CntW'(Window));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nts_q    <= '0;
      old_q    <= '0;
      exp_q    <= '0;
      rwe_q    <= SeqW'(Window % SeqSpace);
      buf_q    <= '0;
      nak_ok_q <= 1'b1;
      phys_q   <= 1'b0;
      marks_q  <= '0;
      valid_o  <= 1'b0;
      rx_ack_q <= 1'b0;
      ok_q     <= 1'b0;
      kind_q   <= KIND_DATA;
      fseq_q   <= '0;
      fack_q   <= '0;
      tseq_q   <= '0;
      iter_q   <= '0;
      action_o <= ACT_DATA;
      seq_o    <= '0;
      piggy_ack_o      <= '0;
      timer_length_o   <= '0;
      network_enable_o <= 1'b0;
      last_o           <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      unique case (op_i)
        OP_NONE: ;
        OP_LATCH: begin
          ok_q     <= frame_ok_i;
          kind_q   <= frame_kind_i;
          fseq_q   <= mod_f(frame_seq_i);
          fack_q   <= mod_f(frame_ack_i);
          tseq_q   <= mod_f(timeout_seq_i);
          rx_ack_q <= 1'b1;
        end
        OP_NET_SEND: begin
          buf_q <= buf_q + 1'b1;
          phys_q <= 1'b0;
          nts_q <= inc_f(nts_q);
          valid_o <= 1'b1;
          action_o <= ACT_DATA; seq_o <= 5'(nts_q); piggy_ack_o <= 5'(piggy);
          timer_length_o <= data_timeout_i; network_enable_o <= 1'b0; last_o <= 1'b0;
        end
        OP_PHYS: phys_q <= 1'b1;
        OP_ACK_SEND: begin
          phys_q <= 1'b0;
          valid_o <= 1'b1;
          action_o <= ACT_ACK; seq_o <= '0; piggy_ack_o <= 5'(piggy);
          timer_length_o <= '0; network_enable_o <= 1'b0; last_o <= 1'b0;
        end
        OP_BAD_FRAME: begin
          valid_o <= 1'b1;
          seq_o <= '0; network_enable_o <= 1'b0; last_o <= 1'b0;
          if (nak_ok_q || fseq_q == exp_q) begin
            nak_ok_q <= 1'b0; phys_q <= 1'b0;
            action_o <= ACT_NAK; piggy_ack_o <= 5'(piggy); timer_length_o <= '0;
          end else begin
            action_o <= ACT_ASTART; piggy_ack_o <= '0; timer_length_o <= ack_timeout_i;
          end
        end
        OP_RX_NAK: begin
          nak_ok_q <= 1'b0; phys_q <= 1'b0; rx_ack_q <= 1'b0;
          valid_o <= 1'b1;
          action_o <= ACT_NAK; seq_o <= '0; piggy_ack_o <= 5'(piggy);
          timer_length_o <= '0; network_enable_o <= 1'b0; last_o <= 1'b0;
        end
        OP_RX_MARK: marks_q[slot_f(fseq_q)] <= 1'b1;
        OP_RX_DELIVER: begin
          nak_ok_q <= 1'b1; rx_ack_q <= 1'b1;
          marks_q[slot_f(exp_q)] <= 1'b0;
          exp_q <= inc_f(exp_q);
          rwe_q <= inc_f(rwe_q);
          valid_o <= 1'b1;
          action_o <= ACT_DELIVER; seq_o <= 5'(exp_q); piggy_ack_o <= '0;
          timer_length_o <= '0; network_enable_o <= 1'b0; last_o <= 1'b0;
        end
        OP_RX_ASTART: begin
          valid_o <= rx_ack_q;
          action_o <= ACT_ASTART; seq_o <= '0; piggy_ack_o <= '0;
          timer_length_o <= ack_timeout_i; network_enable_o <= 1'b0; last_o <= 1'b0;
        end
        OP_NAK_RESEND: begin
          phys_q <= 1'b0;
          valid_o <= 1'b1;
          action_o <= ACT_DATA; seq_o <= 5'(nak_tgt); piggy_ack_o <= 5'(piggy);
          timer_length_o <= data_timeout_i; network_enable_o <= 1'b0; last_o <= 1'b0;
        end
        OP_TSTOP: begin
          if (buf_q != '0) buf_q <= buf_q - 1'b1;
          old_q <= inc_f(old_q);
          valid_o <= 1'b1;
          action_o <= ACT_TSTOP; seq_o <= 5'(old_q); piggy_ack_o <= '0;
          timer_length_o <= '0; network_enable_o <= 1'b0; last_o <= 1'b0;
        end
        OP_TO_SEND: begin
          phys_q <= 1'b0;
          valid_o <= 1'b1;
          action_o <= ACT_DATA; seq_o <= 5'(tseq_q); piggy_ack_o <= 5'(piggy);
          timer_length_o <= data_timeout_i; network_enable_o <= 1'b0; last_o <= 1'b0;
        end
        OP_TO_FIRST: begin
          iter_q <= inc_f(inc_f(tseq_q));
          valid_o <= 1'b1;
          action_o <= ACT_TSTART; seq_o <= 5'(inc_f(tseq_q)); piggy_ack_o <= '0;
          timer_length_o <= resend_stagger_i; network_enable_o <= 1'b0; last_o <= 1'b0;
        end
        OP_TO_NEXT: begin
          iter_q <= inc_f(iter_q);
          valid_o <= 1'b1;
          action_o <= ACT_TSTART; seq_o <= 5'(iter_q); piggy_ack_o <= '0;
          timer_length_o <= later; network_enable_o <= 1'b0; last_o <= 1'b0;
        end
        OP_STATUS: begin
          valid_o <= 1'b1;
          action_o <= ACT_STATUS; seq_o <= '0; piggy_ack_o <= '0; timer_length_o <= '0;
          network_enable_o <= (buf_q < CntW'(Window)) && phys_q;
          last_o <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/sraq_ctrl.sv
// Controller state machine of the ARQ window controller; sequences datapath operations.
// Depends on sraq_pkg.
`default_nettype none
module sraq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [2:0]           command_i,
  input  wire sraq_pkg::dp_status_t status_i,
  output logic                      busy_o,
  output sraq_pkg::op_e             op_o
);
  import sraq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RX_CHECK, S_RX_MARK, S_RX_DELIVER, S_RX_ASTART,
    S_NAK_CHECK, S_TSTOP, S_TO_FIRST, S_TO_NEXT, S_STATUS
  } state_e;

  state_e     state_q;
  logic [2:0] cmd_q;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    op_o = OP_NONE;
    unique case (state_q)
      S_IDLE:       op_o = start_i ? OP_LATCH : OP_NONE;
      S_DISPATCH: begin
        unique case (cmd_q)
          CMD_NET:   op_o = status_i.net_ok ? OP_NET_SEND : OP_NONE;
          CMD_PHYS:  op_o = OP_PHYS;
          CMD_ATO:   op_o = OP_ACK_SEND;
          CMD_DTO:   op_o = OP_TO_SEND;
          CMD_FRAME: op_o = !status_i.ok ? OP_BAD_FRAME : OP_NONE;
          default:   op_o = OP_NONE;
        endcase
      end
      S_RX_CHECK:   op_o = status_i.nak_cond ? OP_RX_NAK : OP_NONE;
      S_RX_MARK:    op_o = status_i.mark_cond ? OP_RX_MARK : OP_NONE;
      S_RX_DELIVER: op_o = status_i.deliver_rdy ? OP_RX_DELIVER : OP_NONE;
      S_RX_ASTART:  op_o = OP_RX_ASTART;
      S_NAK_CHECK:  op_o = status_i.resend_cond ? OP_NAK_RESEND : OP_NONE;
      S_TSTOP:      op_o = status_i.ack_pending ? OP_TSTOP : OP_NONE;
      S_TO_FIRST:   op_o = OP_TO_FIRST;
      S_TO_NEXT:    op_o = status_i.to_more ? OP_TO_NEXT : OP_NONE;
      S_STATUS:     op_o = OP_STATUS;
      default:      op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_NET;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_q   <= command_i;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (cmd_q == CMD_FRAME && status_i.ok) begin
            state_q <= status_i.is_data ? S_RX_CHECK :
                       status_i.is_nak ? S_NAK_CHECK : S_TSTOP;
          end else if (cmd_q == CMD_DTO) begin
            state_q <= S_TO_FIRST;
          end else begin
            state_q <= S_STATUS;
          end
        end
        S_RX_CHECK:   state_q <= S_RX_MARK;
        S_RX_MARK:    state_q <= status_i.mark_cond ? S_RX_DELIVER : S_RX_ASTART;
        S_RX_DELIVER: if (!status_i.deliver_rdy) state_q <= S_RX_ASTART;
        S_RX_ASTART:  state_q <= S_TSTOP;
        S_NAK_CHECK:  state_q <= S_TSTOP;
        S_TSTOP:      if (!status_i.ack_pending) state_q <= S_STATUS;
        S_TO_FIRST:   state_q <= S_TO_NEXT;
        S_TO_NEXT:    if (!status_i.to_more) state_q <= S_STATUS;
        S_STATUS:     state_q <= S_IDLE;
        default:      state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/selective_repeat_arq_controller.sv
// Top level of the selective-repeat ARQ window controller: APB register bank,
// controller and datapath. Depends on sraq_pkg, sraq_ctrl and sraq_datapath.
//
//  Channel   Signals                                   Transaction
//  event     start_i, busy_o, command_i, frame_*_i,    start_i high while busy_o low
//            timeout_seq_i
//  result    valid_o, action_o, seq_o, piggy_ack_o,    one cycle with valid_o high
//            timer_length_o, network_enable_o, last_o
//  config    psel, penable, pwrite, paddr, pwdata,     psel, penable, pwrite, pready high
//            prdata, pready
//
// One event is processed at a time. After acceptance a dispatch state issues the first
// action, if any, each loop (deliveries, timer stops, timer restarts) issues one step per
// cycle until it finds its end, and a final state issues the status item; each result is
// registered and shown in the cycle after it is issued. The longest event is a data frame
// that delivers 16 slots and releases 16 frames. Reset is asynchronous and active low and
// restores all windows, marks and registers. The receiver cannot stall: each result is
// shown for exactly one cycle.
`default_nettype none
module selective_repeat_arq_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  command_i,
  input  wire logic        frame_ok_i,
  input  wire logic [1:0]  frame_kind_i,
  input  wire logic [4:0]  frame_seq_i,
  input  wire logic [4:0]  frame_ack_i,
  input  wire logic [4:0]  timeout_seq_i,
  output logic             valid_o,
  output logic [2:0]       action_o,
  output logic [4:0]       seq_o,
  output logic [4:0]       piggy_ack_o,
  output logic [15:0]      timer_length_o,
  output logic             network_enable_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sraq_pkg::*;

  localparam logic [1:0] REG_DATA_TO = 2'd0;
  localparam logic [1:0] REG_ACK_TO  = 2'd1;
  localparam logic [1:0] REG_STAGGER = 2'd2;

  logic [15:0] data_to_q, ack_to_q, stagger_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register file: three 16-bit timer lengths at byte addresses 0, 4 and 8.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_to_q <= DATA_TO_RST;
      ack_to_q  <= ACK_TO_RST;
      stagger_q <= STAGGER_RST;
    end else if (wr_en) begin
      if (paddr[3:2] == REG_DATA_TO) data_to_q <= pwdata[15:0];
      if (paddr[3:2] == REG_ACK_TO)  ack_to_q  <= pwdata[15:0];
      if (paddr[3:2] == REG_STAGGER) stagger_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_DATA_TO: prdata = {16'd0, data_to_q};
      REG_ACK_TO:  prdata = {16'd0, ack_to_q};
      REG_STAGGER: prdata = {16'd0, stagger_q};
      default:     prdata = '0;
    endcase
  end

  dp_status_t status;
  op_e        op;

  sraq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .command_i(command_i),
    .status_i (status),
    .busy_o   (busy_o),
    .op_o     (op)
  );

  sraq_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .frame_ok_i      (frame_ok_i),
    .frame_kind_i    (frame_kind_i),
    .frame_seq_i     (frame_seq_i),
    .frame_ack_i     (frame_ack_i),
    .timeout_seq_i   (timeout_seq_i),
    .data_timeout_i  (data_to_q),
    .ack_timeout_i   (ack_to_q),
    .resend_stagger_i(stagger_q),
    .status_o        (status),
    .valid_o         (valid_o),
    .action_o        (action_o),
    .seq_o           (seq_o),
    .piggy_ack_o     (piggy_ack_o),
    .timer_length_o  (timer_length_o),
    .network_enable_o(network_enable_o),
    .last_o          (last_o)
  );
endmodule
`default_nettype wire
